// File: src/ffpc_pkg.sv
// ----------------------------------------------------------------------------
// ffpc_pkg
// Shared constants and types for the flat-field pixel correction pipeline.
// ----------------------------------------------------------------------------
package ffpc_pkg;

   localparam int PIXEL_BITS_DEF     = 16;
   localparam int FLAT_FRAC_BITS_DEF = 15;

   // Control and status register port.
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_FLAT    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BIAS_ENABLE = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DARK_ENABLE = 2'd2;

   localparam logic [CSR_DATA_W-1:0] MIN_FLAT_RESET    = 16'd328;
   localparam logic                  BIAS_ENABLE_RESET = 1'b1;
   localparam logic                  DARK_ENABLE_RESET = 1'b1;

   // Status that travels with each request down the pipeline.
   typedef struct packed {
      logic negative;   // bias and dark exceed the raw pixel
      logic below;      // flat gain at or below the minimum
      logic overflow;   // exact quotient is at least 2^PIXEL_BITS
   } ffpc_flags_type;

endpackage

// File: src/ffpc_div_stage.sv
// ----------------------------------------------------------------------------
// ffpc_div_stage
// One register stage of the restoring divider: retires STEPS quotient bits.
// ----------------------------------------------------------------------------
module ffpc_div_stage import ffpc_pkg::*; #(
   parameter int GAIN_W     = FLAT_FRAC_BITS_DEF + 1,
   parameter int PIXEL_BITS = PIXEL_BITS_DEF,
   parameter int STEPS      = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [GAIN_W-1:0]     in_rem,
   input  logic [GAIN_W-1:0]     in_div,
   input  logic [PIXEL_BITS-1:0] in_low,
   input  logic [PIXEL_BITS-1:0] in_quo,
   input  ffpc_flags_type        in_flags,
   output logic                  out_valid,
   output logic [GAIN_W-1:0]     out_rem,
   output logic [GAIN_W-1:0]     out_div,
   output logic [PIXEL_BITS-1:0] out_low,
   output logic [PIXEL_BITS-1:0] out_quo,
   output ffpc_flags_type        out_flags
);

   logic                  valid_ff;
   logic [GAIN_W-1:0]     rem_ff, rem_in;
   logic [GAIN_W-1:0]     div_ff;
   logic [PIXEL_BITS-1:0] low_ff, low_in;
   logic [PIXEL_BITS-1:0] quo_ff, quo_in;
   ffpc_flags_type        flags_ff;
   logic [GAIN_W:0]       trial;

   // The partial remainder stays below the divisor, so each trial fits in
   // one bit more than the divisor.
   always_comb begin
      rem_in = in_rem;
      low_in = in_low;
      quo_in = in_quo;
      trial  = '0;
      for (int k = 0; k < STEPS; k++) begin
         trial  = {rem_in, low_in[PIXEL_BITS-1]};
         low_in = {low_in[PIXEL_BITS-2:0], 1'b0};
         if (trial >= {1'b0, in_div}) begin
            rem_in = GAIN_W'(trial - {1'b0, in_div});
            quo_in = {quo_in[PIXEL_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[GAIN_W-1:0];
            quo_in = {quo_in[PIXEL_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff   <= rem_in;
         div_ff   <= in_div;
         low_ff   <= low_in;
         quo_ff   <= quo_in;
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_div   = div_ff;
   assign out_low   = low_ff;
   assign out_quo   = quo_ff;
   assign out_flags = flags_ff;

endmodule

// File: src/flat_field_pixel_correction.sv
// ----------------------------------------------------------------------------
// flat_field_pixel_correction
// Bias and dark subtraction, flat division with round-half-even, saturation.
// ----------------------------------------------------------------------------
// The block accepts one pixel request per clock while req_stall is low and
// returns one result per request, in order. From acceptance to the result
// register, one stage forms the signed difference and the clamped divisor,
// one checks for quotient overflow, the restoring divider retires two quotient
// bits per stage (one in its last stage when PIXEL_BITS is odd), and the last
// stage rounds and saturates. All stages advance together; a stalled result
// holds the whole pipeline and req_stall rises.
// ----------------------------------------------------------------------------
module flat_field_pixel_correction import ffpc_pkg::*; #(
   parameter int PIXEL_BITS     = PIXEL_BITS_DEF,
   parameter int FLAT_FRAC_BITS = FLAT_FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_ADDR_W-1:0]     csr_addr,
   input  logic [CSR_DATA_W-1:0]     csr_wdata,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [PIXEL_BITS-1:0]     req_raw_pixel,
   input  logic [PIXEL_BITS-1:0]     req_bias_level,
   input  logic [PIXEL_BITS-1:0]     req_dark_level,
   input  logic [FLAT_FRAC_BITS:0]   req_flat_gain,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [PIXEL_BITS-1:0]     rsp_corrected_pixel,
   output logic                      rsp_flat_below_min,
   output logic                      rsp_over_range,
   output logic                      rsp_under_range
);

   localparam int GAIN_W     = FLAT_FRAC_BITS + 1;
   localparam int DIFF_W     = PIXEL_BITS + 1;
   localparam int NUM_W      = DIFF_W + FLAT_FRAC_BITS;
   localparam int DIV_STAGES = (PIXEL_BITS + 1) / 2;
   localparam int MIN_EXT_W  = (GAIN_W > CSR_DATA_W) ? GAIN_W : CSR_DATA_W;

   logic advance;

   // Configuration registers.
   logic [CSR_DATA_W-1:0] min_flat_ff;
   logic                  bias_enable_ff;
   logic                  dark_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_flat_ff    <= MIN_FLAT_RESET;
         bias_enable_ff <= BIAS_ENABLE_RESET;
         dark_enable_ff <= DARK_ENABLE_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MIN_FLAT:    min_flat_ff    <= csr_wdata;
            CSR_BIAS_ENABLE: bias_enable_ff <= csr_wdata[0];
            CSR_DARK_ENABLE: dark_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Stage 1: signed difference as sign and magnitude, clamped divisor.
   logic [DIFF_W-1:0]    bias_term, dark_term, sub_sum, raw_ext, mag_in;
   logic                 negative_in, below_in;
   logic [MIN_EXT_W-1:0] min_ext;
   logic [GAIN_W-1:0]    min_val, div_in;

   always_comb begin
      bias_term   = bias_enable_ff ? {1'b0, req_bias_level} : '0;
      dark_term   = dark_enable_ff ? {1'b0, req_dark_level} : '0;
      sub_sum     = bias_term + dark_term;
      raw_ext     = {1'b0, req_raw_pixel};
      negative_in = sub_sum > raw_ext;
      mag_in      = negative_in ? (sub_sum - raw_ext) : (raw_ext - sub_sum);
      min_ext     = MIN_EXT_W'(min_flat_ff);
      min_val     = min_ext[GAIN_W-1:0];
      below_in    = req_flat_gain <= min_val;
      div_in      = below_in ? min_val : req_flat_gain;
      // A zero minimum is used as one so the divisor is never zero.
      if (div_in == '0) begin
         div_in = GAIN_W'(1);
      end
   end

   logic              s1_valid_ff;
   logic [DIFF_W-1:0] s1_mag_ff;
   logic [GAIN_W-1:0] s1_div_ff;
   ffpc_flags_type    s1_flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_mag_ff            <= mag_in;
         s1_div_ff            <= div_in;
         s1_flags_ff.negative <= negative_in;
         s1_flags_ff.below    <= below_in;
         s1_flags_ff.overflow <= 1'b0;
      end
   end

   // Stage 2: the quotient overflows the pixel range exactly when the
   // scaled numerator reaches the divisor shifted up by the pixel width.
   logic [NUM_W-1:0] num_in, div_shift;
   logic             overflow_in;
   ffpc_flags_type   s2_flags_in;

   always_comb begin
      num_in               = {s1_mag_ff, FLAT_FRAC_BITS'(0)};
      div_shift            = {s1_div_ff, PIXEL_BITS'(0)};
      overflow_in          = num_in >= div_shift;
      s2_flags_in          = s1_flags_ff;
      s2_flags_in.overflow = overflow_in;
   end

   logic                  s2_valid_ff;
   logic [GAIN_W-1:0]     s2_rem_ff;
   logic [GAIN_W-1:0]     s2_div_ff;
   logic [PIXEL_BITS-1:0] s2_low_ff;
   ffpc_flags_type        s2_flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_rem_ff   <= num_in[NUM_W-1:PIXEL_BITS];
         s2_div_ff   <= s1_div_ff;
         s2_low_ff   <= num_in[PIXEL_BITS-1:0];
         s2_flags_ff <= s2_flags_in;
      end
   end

   // Divider stages.
   logic                  dv_valid [DIV_STAGES+1];
   logic [GAIN_W-1:0]     dv_rem   [DIV_STAGES+1];
   logic [GAIN_W-1:0]     dv_div   [DIV_STAGES+1];
   logic [PIXEL_BITS-1:0] dv_low   [DIV_STAGES+1];
   logic [PIXEL_BITS-1:0] dv_quo   [DIV_STAGES+1];
   ffpc_flags_type        dv_flags [DIV_STAGES+1];

   assign dv_valid[0] = s2_valid_ff;
   assign dv_rem[0]   = s2_rem_ff;
   assign dv_div[0]   = s2_div_ff;
   assign dv_low[0]   = s2_low_ff;
   assign dv_quo[0]   = '0;
   assign dv_flags[0] = s2_flags_ff;

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      localparam int STEPS = ((2 * s + 2) > PIXEL_BITS) ? 1 : 2;

      ffpc_div_stage #(
         .GAIN_W     (GAIN_W),
         .PIXEL_BITS (PIXEL_BITS),
         .STEPS      (STEPS)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (dv_valid[s]),
         .in_rem    (dv_rem[s]),
         .in_div    (dv_div[s]),
         .in_low    (dv_low[s]),
         .in_quo    (dv_quo[s]),
         .in_flags  (dv_flags[s]),
         .out_valid (dv_valid[s+1]),
         .out_rem   (dv_rem[s+1]),
         .out_div   (dv_div[s+1]),
         .out_low   (dv_low[s+1]),
         .out_quo   (dv_quo[s+1]),
         .out_flags (dv_flags[s+1])
      );
   end

   // Final stage: round half to even, then saturate.
   logic [GAIN_W:0]       twice_rem, div_ext;
   logic                  round_up;
   logic [PIXEL_BITS:0]   quo_round;
   ffpc_flags_type        fin_flags;
   logic                  over_in, under_in;
   logic [PIXEL_BITS-1:0] pixel_in;

   always_comb begin
      fin_flags = dv_flags[DIV_STAGES];
      twice_rem = {dv_rem[DIV_STAGES], 1'b0};
      div_ext   = {1'b0, dv_div[DIV_STAGES]};
      round_up  = (twice_rem > div_ext)
                  || ((twice_rem == div_ext) && dv_quo[DIV_STAGES][0]);
      quo_round = {1'b0, dv_quo[DIV_STAGES]} + (PIXEL_BITS + 1)'(round_up);
      over_in   = !fin_flags.negative && (fin_flags.overflow || quo_round[PIXEL_BITS]);
      under_in  = fin_flags.negative && (fin_flags.overflow || (quo_round != '0));
      if (fin_flags.negative) begin
         pixel_in = '0;
      end else if (over_in) begin
         pixel_in = '1;
      end else begin
         pixel_in = quo_round[PIXEL_BITS-1:0];
      end
   end

   logic                  rsp_valid_ff;
   logic [PIXEL_BITS-1:0] rsp_pixel_ff;
   logic                  rsp_below_ff;
   logic                  rsp_over_ff;
   logic                  rsp_under_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_valid[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pixel_ff <= pixel_in;
         rsp_below_ff <= fin_flags.below;
         rsp_over_ff  <= over_in;
         rsp_under_ff <= under_in;
      end
   end

   // The pipeline moves whenever the result register is empty or drained.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_corrected_pixel = rsp_pixel_ff;
   assign rsp_flat_below_min  = rsp_below_ff;
   assign rsp_over_range      = rsp_over_ff;
   assign rsp_under_range     = rsp_under_ff;

   // Assertions.
   a_clip_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_over_ff && rsp_under_ff))
      else $error("over_range and under_range both set");

   a_over_saturates: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_over_ff) |-> (rsp_pixel_ff == '1))
      else $error("over_range without a saturated pixel");

   a_under_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_under_ff) |-> (rsp_pixel_ff == '0))
      else $error("under_range without a zero pixel");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !advance) |=> (s2_valid_ff && $stable(s2_rem_ff)))
      else $error("pipeline stage changed while held");

endmodule

// File: sim/ffpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpc_checker
// Watches the request, result and register ports of the flat-field pixel
// correction block. It predicts each corrected pixel from the accepted request
// and the current register settings, and compares it with the returned result.
// ----------------------------------------------------------------------------
module ffpc_checker import ffpc_pkg::*; #(
   parameter int PIXEL_BITS     = PIXEL_BITS_DEF,
   parameter int FLAT_FRAC_BITS = FLAT_FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CSR_ADDR_W-1:0]   csr_addr,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [PIXEL_BITS-1:0]   req_raw_pixel,
   input  logic [PIXEL_BITS-1:0]   req_bias_level,
   input  logic [PIXEL_BITS-1:0]   req_dark_level,
   input  logic [FLAT_FRAC_BITS:0] req_flat_gain,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic [PIXEL_BITS-1:0]   rsp_corrected_pixel,
   input  logic                    rsp_flat_below_min,
   input  logic                    rsp_over_range,
   input  logic                    rsp_under_range,
   output int                      fail_count,
   output int                      pending_count
);

   localparam logic [PIXEL_BITS-1:0] PIXEL_MAX = '1;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic                  below;
      logic                  over;
      logic                  under;
   } corrected_type;

   logic [FLAT_FRAC_BITS:0] min_gain;
   logic                    bias_on;
   logic                    dark_on;
   corrected_type           expected_pixels[$];
   int                      fails = 0;

   function automatic corrected_type predict_correction(
      input logic [PIXEL_BITS-1:0]   raw,
      input logic [PIXEL_BITS-1:0]   bias,
      input logic [PIXEL_BITS-1:0]   dark,
      input logic [FLAT_FRAC_BITS:0] gain
   );
      logic [PIXEL_BITS+1:0]   offset;
      logic [PIXEL_BITS+1:0]   magnitude;
      logic                    negative;
      logic [FLAT_FRAC_BITS:0] divisor;
      logic [63:0]             numerator;
      logic [63:0]             quotient;
      logic [63:0]             remainder;
      corrected_type           result;
      offset = '0;
      if (bias_on) offset = offset + bias;
      if (dark_on) offset = offset + dark;
      negative  = offset > raw;
      magnitude = negative ? offset - raw : raw - offset;
      result       = '0;
      result.below = gain <= min_gain;
      divisor      = (gain > min_gain) ? gain : min_gain;
      // A zero minimum with a zero gain still divides by one.
      if (divisor == '0) divisor = (FLAT_FRAC_BITS + 1)'(1);
      numerator = 64'(magnitude) << FLAT_FRAC_BITS;
      quotient  = numerator / divisor;
      remainder = numerator % divisor;
      // Round to nearest, with exact halves going to the even quotient.
      if ((remainder << 1) > divisor || ((remainder << 1) == divisor && quotient[0]))
         quotient = quotient + 64'd1;
      if (negative) begin
         result.under = quotient != 0;
      end else if (quotient > 64'(PIXEL_MAX)) begin
         result.over  = 1'b1;
         result.pixel = PIXEL_MAX;
      end else begin
         result.pixel = quotient[PIXEL_BITS-1:0];
      end
      return result;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin : monitor
      corrected_type want;
      if (reset) begin
         min_gain <= MIN_FLAT_RESET[FLAT_FRAC_BITS:0];
         bias_on  <= BIAS_ENABLE_RESET;
         dark_on  <= DARK_ENABLE_RESET;
         expected_pixels.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_MIN_FLAT:    min_gain <= csr_wdata[FLAT_FRAC_BITS:0];
               CSR_BIAS_ENABLE: bias_on  <= csr_wdata[0];
               CSR_DARK_ENABLE: dark_on  <= csr_wdata[0];
               default: ;
            endcase
         end
         // Results are matched before new requests are queued, so a result can
         // never be paired with a request accepted at the same edge.
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("result with no request outstanding: corrected_pixel %0d",
                      rsp_corrected_pixel);
               fails++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("corrected_pixel", 32'(want.pixel), 32'(rsp_corrected_pixel));
               check_field("flat_below_min", 32'(want.below), 32'(rsp_flat_below_min));
               check_field("over_range", 32'(want.over), 32'(rsp_over_range));
               check_field("under_range", 32'(want.under), 32'(rsp_under_range));
            end
         end
         if (req_valid && !req_stall)
            expected_pixels.insert(expected_pixels.size(),
                                   predict_correction(req_raw_pixel, req_bias_level,
                                                      req_dark_level, req_flat_gain));
      end
      fail_count    <= fails;
      pending_count <= expected_pixels.size();
   end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the flat-field pixel correction block with corner pixels and then
// random pixel streams under several register settings and idle patterns.
// A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top import ffpc_pkg::*; ();

   localparam int PIX_W           = PIXEL_BITS_DEF;
   localparam int GAIN_W          = FLAT_FRAC_BITS_DEF + 1;
   localparam int ITEMS_PER_PHASE = 170;
   localparam int PHASES          = 6;
   localparam int DRAIN_CYCLES    = 24;
   localparam int WATCHDOG_LIMIT  = 2000;

   typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  csr_we         = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr       = CSR_MIN_FLAT;
   logic [CSR_DATA_W-1:0] csr_wdata      = '0;
   logic                  req_valid      = 1'b0;
   logic [PIX_W-1:0]      req_raw_pixel  = '0;
   logic [PIX_W-1:0]      req_bias_level = '0;
   logic [PIX_W-1:0]      req_dark_level = '0;
   logic [GAIN_W-1:0]     req_flat_gain  = '0;
   logic                  rsp_stall      = 1'b0;
   logic                  req_stall;
   logic                  rsp_valid;
   logic [PIX_W-1:0]      rsp_corrected_pixel;
   logic                  rsp_flat_below_min;
   logic                  rsp_over_range;
   logic                  rsp_under_range;

   idle_mode_type         idle_mode    = IDLE_NONE;
   logic [GAIN_W-1:0]     min_setting  = MIN_FLAT_RESET[GAIN_W-1:0];
   int                    quiet_cycles = 0;
   int                    fail_count;
   int                    pending_count;

   flat_field_pixel_correction dut (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_addr            (csr_addr),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_raw_pixel       (req_raw_pixel),
      .req_bias_level      (req_bias_level),
      .req_dark_level      (req_dark_level),
      .req_flat_gain       (req_flat_gain),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_corrected_pixel (rsp_corrected_pixel),
      .rsp_flat_below_min  (rsp_flat_below_min),
      .rsp_over_range      (rsp_over_range),
      .rsp_under_range     (rsp_under_range)
   );

   ffpc_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_addr            (csr_addr),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_raw_pixel       (req_raw_pixel),
      .req_bias_level      (req_bias_level),
      .req_dark_level      (req_dark_level),
      .req_flat_gain       (req_flat_gain),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_corrected_pixel (rsp_corrected_pixel),
      .rsp_flat_below_min  (rsp_flat_below_min),
      .rsp_over_range      (rsp_over_range),
      .rsp_under_range     (rsp_under_range),
      .fail_count          (fail_count),
      .pending_count       (pending_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int idle_pct(input idle_mode_type mode, input logic receiver);
      case (mode)
         IDLE_SEND: return receiver ? 0 : 70;
         IDLE_RECV: return receiver ? 70 : 0;
         IDLE_BOTH: return 15;
         default:   return 0;
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_stall <= $urandom_range(99) < idle_pct(idle_mode, 1'b1);
   end

   // The run ends if no request and no result moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("flat_field_pixel_correction verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_pixel(input logic [PIX_W-1:0] raw, input logic [PIX_W-1:0] bias,
                             input logic [PIX_W-1:0] dark, input logic [GAIN_W-1:0] gain);
      while ($urandom_range(99) < idle_pct(idle_mode, 1'b0)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_raw_pixel  <= raw;
      req_bias_level <= bias;
      req_dark_level <= dark;
      req_flat_gain  <= gain;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_random_pixel();
      logic [PIX_W-1:0]  raw;
      logic [PIX_W-1:0]  bias;
      logic [PIX_W-1:0]  dark;
      logic [GAIN_W-1:0] gain;
      int                near_offset;
      raw  = PIX_W'($urandom_range(0, 65535));
      bias = PIX_W'($urandom_range(0, 1500));
      dark = PIX_W'($urandom_range(0, 900));
      case ($urandom_range(0, 9))
         0: begin
            bias = PIX_W'($urandom_range(0, 65535));
            dark = PIX_W'($urandom_range(0, 65535));
         end
         // Raw pixels close to the combined offset exercise the sign boundary.
         1, 2: begin
            near_offset = int'(bias) + int'(dark) + int'($urandom_range(0, 60)) - 30;
            raw = (near_offset < 0) ? '0 : PIX_W'(near_offset);
         end
         default: ;
      endcase
      case ($urandom_range(0, 9))
         0:       gain = '0;
         1:       gain = min_setting + GAIN_W'($urandom_range(0, 4)) - GAIN_W'(2);
         2:       gain = GAIN_W'($urandom_range(1, 1000));
         3:       gain = GAIN_W'(32768);
         4:       gain = GAIN_W'($urandom_range(32769, 65535));
         default: gain = GAIN_W'($urandom_range(8192, 32768));
      endcase
      send_pixel(raw, bias, dark, gain);
   endtask

   task automatic write_settings(input logic [CSR_DATA_W-1:0] min_flat, input logic bias_en,
                                 input logic dark_en);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_MIN_FLAT;
      csr_wdata <= min_flat;
      @(posedge clock);
      csr_addr  <= CSR_BIAS_ENABLE;
      csr_wdata <= CSR_DATA_W'(bias_en);
      @(posedge clock);
      csr_addr  <= CSR_DARK_ENABLE;
      csr_wdata <= CSR_DATA_W'(dark_en);
      @(posedge clock);
      csr_we      <= 1'b0;
      min_setting  = min_flat[GAIN_W-1:0];
   endtask

   // Lower valid and wait for every outstanding result. The checker's count is
   // registered, so the task waits on the clock before it first looks at it.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Corner pixels under the reset settings.
      send_pixel(16'd0, 16'd0, 16'd0, 16'd0);
      send_pixel(16'hFFFF, 16'd0, 16'd0, 16'h8000);
      send_pixel(16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
      send_pixel(16'hFFFF, 16'd0, 16'd0, 16'd328);
      send_pixel(16'hFFFF, 16'd0, 16'd0, 16'd329);
      send_pixel(16'd40000, 16'd0, 16'd0, 16'd327);
      send_pixel(16'd0, 16'hFFFF, 16'hFFFF, 16'h8000);
      send_pixel(16'd100, 16'd60, 16'd41, 16'hFFFF);
      send_pixel(16'd200, 16'd60, 16'd40, 16'h8000);
      send_pixel(16'd1000, 16'd300, 16'd200, 16'd16384);
      send_pixel(16'hAAAA, 16'h5555, 16'h0F0F, 16'h8000);
      send_pixel(16'h5555, 16'hAAAA, 16'd0, 16'h7FFF);

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            wait_for_results();
            case (phase)
               1:       write_settings(16'd1, 1'b0, 1'b0);
               2:       write_settings(16'd32768, 1'b1, 1'b0);
               3:       write_settings(16'd0, 1'b0, 1'b1);
               4:       write_settings(16'hFFFF, 1'b1, 1'b1);
               default: write_settings(CSR_DATA_W'($urandom_range(1, 32768)),
                                       1'($urandom_range(0, 1)),
                                       1'($urandom_range(0, 1)));
            endcase
            send_pixel(16'd1000, 16'd10, 16'd20, '0);
            send_pixel(16'hFFFF, 16'd0, 16'd0, min_setting);
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            idle_mode <= idle_mode_type'((n / 40) % 4);
            send_random_pixel();
         end
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("flat_field_pixel_correction verification clean");
      end else begin
         $display("flat_field_pixel_correction verification failed");
      end
      $finish;
   end

endmodule
